[rtl/core/maat_pkg.sv]
`default_nettype none

package maat_pkg;

    localparam int TableEntries = 64;
    localparam int IdxW = $clog2(TableEntries);
    localparam int CntW = $clog2(TableEntries + 1);
    localparam int EntryW = 24;

    localparam logic [15:0] BlankQuery = 16'hFFFF;

    // result status codes
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_BAD_ID = 3'd3;
    localparam logic [2:0] ST_NO_FREE = 3'd4;
    localparam logic [2:0] ST_MISMATCH = 3'd5;

    // input operation codes
    localparam logic [2:0] OP_SET = 3'd0;
    localparam logic [2:0] OP_ADDR_BY_ID = 3'd1;
    localparam logic [2:0] OP_ID_BY_ADDR = 3'd2;
    localparam logic [2:0] OP_RELEASE = 3'd3;
    localparam logic [2:0] OP_ALLOCATE = 3'd4;
    localparam logic [2:0] OP_CONFIRM = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_DEFAULT_ADDRESS = 2'd0;
    localparam logic [1:0] REG_MAX_CHILDREN = 2'd1;
    localparam logic [1:0] REG_OWN_NODE_ID = 2'd2;

    typedef enum logic [2:0] {
        CMD_SET,
        CMD_FIND_ID,
        CMD_FIND_ADDR,
        CMD_RELEASE,
        CMD_ALLOC,
        CMD_CONFIRM,
        CMD_DIRECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  id;
        logic [15:0] addr;
        logic [15:0] base;
        logic [4:0]  shift;
        logic [3:0]  top;
        logic [2:0]  status;
        logic [7:0]  id_out;
    } cmd_t;

    typedef struct packed {
        logic [15:0] default_address;
        logic [2:0]  max_children;
        logic [7:0]  own_node_id;
    } cfg_t;

    typedef struct packed {
        logic            busy;
        logic [CntW-1:0] count;
    } back_stat_t;

endpackage

`default_nettype wire

[rtl/core/maat_ram.sv]
`default_nettype none

module maat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/maat_front.sv]
`default_nettype none

module maat_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire maat_pkg::cfg_t        cfg,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [2:0]            operation,
    input  wire logic [7:0]            node_id,
    input  wire logic [15:0]           address,
    output logic                       q_valid,
    output maat_pkg::cmd_t             q_data,
    input  wire logic                  q_pop
);

    maat_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     fill_reg;
    maat_pkg::cmd_t cmd;
    logic [17:0]    addr_ext;
    logic [4:0]     shift;
    logic           push;

    assign in_stall = (fill_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (fill_reg != 2'd0);
    assign q_data = q_reg[rd_ptr_reg];
    assign addr_ext = {2'b00, address};

    // shift past the highest non-zero octal digit of the sender address (three bits per digit)
    always_comb
    begin
        shift = 5'd0;
        for (int d = 0; d < 6; d++)
        begin
            if (addr_ext[3*d +: 3] != 3'd0)
            begin
                shift = 5'(3 * (d + 1));
            end
        end
    end

    // classify the incoming transfer
    always_comb
    begin
        cmd.kind = maat_pkg::CMD_DIRECT;
        cmd.id = node_id;
        cmd.addr = address;
        cmd.base = address;
        cmd.shift = shift;
        cmd.top = {1'b0, cfg.max_children};
        cmd.status = maat_pkg::ST_OK;
        cmd.id_out = 8'd0;
        if (address == cfg.default_address)
        begin
            cmd.base = 16'd0;
            cmd.shift = 5'd0;
            cmd.top = {1'b0, cfg.max_children} + 4'd1;
        end
        case (operation)
            maat_pkg::OP_SET:        cmd.kind = maat_pkg::CMD_SET;
            maat_pkg::OP_ADDR_BY_ID: cmd.kind = maat_pkg::CMD_FIND_ID;
            maat_pkg::OP_ID_BY_ADDR:
            begin
                if (address == maat_pkg::BlankQuery)
                begin
                    cmd.id_out = cfg.own_node_id;
                end
                else if (address != 16'd0)
                begin
                    cmd.kind = maat_pkg::CMD_FIND_ADDR;
                end
            end
            maat_pkg::OP_RELEASE:    cmd.kind = maat_pkg::CMD_RELEASE;
            maat_pkg::OP_ALLOCATE:
            begin
                if (node_id == 8'd0)
                begin
                    cmd.status = maat_pkg::ST_BAD_ID;
                end
                else
                begin
                    cmd.kind = maat_pkg::CMD_ALLOC;
                end
            end
            maat_pkg::OP_CONFIRM:    cmd.kind = maat_pkg::CMD_CONFIRM;
            default:                 cmd.kind = maat_pkg::CMD_DIRECT;
        endcase
    end

    // hold classified commands for the back end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/core/maat_back.sv]
`default_nettype none

module maat_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire maat_pkg::cfg_t  cfg,
    input  wire logic            q_valid,
    input  wire maat_pkg::cmd_t  q_data,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [2:0]           status,
    output logic [15:0]          address_out,
    output logic [7:0]           node_id_out,
    output maat_pkg::back_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_SCAN,
        S_CHECK,
        S_FINISH,
        S_DONE
    } state_t;

    state_t                        state_reg;
    maat_pkg::cmd_t                cur_reg;
    logic [maat_pkg::CntW-1:0]     count_reg;
    logic [maat_pkg::CntW-1:0]     k_reg;
    logic [3:0]                    i_reg;
    logic [15:0]                   cand_reg;
    logic [15:0]                   pend_addr_reg;
    logic [7:0]                    pend_id_reg;
    logic [2:0]                    res_status_reg;
    logic [15:0]                   res_addr_reg;
    logic [7:0]                    res_id_reg;
    logic                          out_valid_reg;
    logic [2:0]                    status_reg;
    logic [15:0]                   address_out_reg;
    logic [7:0]                    node_id_out_reg;

    logic                          we;
    logic [maat_pkg::IdxW-1:0]     waddr;
    logic [maat_pkg::EntryW-1:0]   wdata;
    logic [maat_pkg::EntryW-1:0]   rdata;
    logic [7:0]                    e_id;
    logic [15:0]                   e_addr;
    logic [23:0]                   shifted;
    logic [15:0]                   cand;
    logic                          id_hit;
    logic                          addr_hit;
    logic                          held;
    logic                          full;
    logic                          confirm_hit;
    maat_pkg::cmd_t                load_cmd;

    maat_ram #(
        .WIDTH(maat_pkg::EntryW),
        .DEPTH(maat_pkg::TableEntries)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(k_reg[maat_pkg::IdxW-1:0]),
        .rdata(rdata)
    );

    assign e_id = rdata[23:16];
    assign e_addr = rdata[15:0];
    assign shifted = {20'd0, i_reg} << cur_reg.shift;
    assign cand = cur_reg.base | shifted[15:0];
    assign id_hit = (e_id == cur_reg.id);
    assign addr_hit = (e_addr == cur_reg.addr);
    assign held = (e_addr == cand_reg) && !id_hit;
    assign full = (count_reg >= maat_pkg::CntW'(maat_pkg::TableEntries));
    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign confirm_hit = (q_data.addr == pend_addr_reg);

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign address_out = address_out_reg;
    assign node_id_out = node_id_out_reg;
    assign stat.busy = (state_reg != S_IDLE);
    assign stat.count = count_reg;

    // turn a matching confirm into a set of the pending pair
    always_comb
    begin
        load_cmd = q_data;
        if (q_data.kind == maat_pkg::CMD_CONFIRM && confirm_hit)
        begin
            load_cmd.kind = maat_pkg::CMD_SET;
            load_cmd.id = pend_id_reg;
            load_cmd.addr = pend_addr_reg;
        end
    end

    // table writes: update in place, release, append
    always_comb
    begin
        we = 1'b0;
        waddr = k_reg[maat_pkg::IdxW-1:0];
        wdata = {cur_reg.id, cur_reg.addr};
        if (state_reg == S_CHECK)
        begin
            if (cur_reg.kind == maat_pkg::CMD_SET && id_hit)
            begin
                we = 1'b1;
            end
            else if (cur_reg.kind == maat_pkg::CMD_RELEASE && addr_hit)
            begin
                we = 1'b1;
                wdata = {e_id, 16'd0};
            end
        end
        else if (state_reg == S_FINISH && cur_reg.kind == maat_pkg::CMD_SET && !full)
        begin
            we = 1'b1;
            waddr = count_reg[maat_pkg::IdxW-1:0];
        end
    end

    // sequence one command at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_addr_reg <= 16'd0;
            pend_id_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg <= load_cmd;
                        k_reg <= '0;
                        i_reg <= q_data.top;
                        res_status_reg <= q_data.status;
                        res_addr_reg <= 16'd0;
                        res_id_reg <= q_data.id_out;
                        case (q_data.kind)
                            maat_pkg::CMD_DIRECT: state_reg <= S_DONE;
                            maat_pkg::CMD_ALLOC:  state_reg <= S_CAND;
                            maat_pkg::CMD_CONFIRM:
                            begin
                                if (confirm_hit)
                                begin
                                    state_reg <= S_SCAN;
                                end
                                else
                                begin
                                    res_status_reg <= maat_pkg::ST_MISMATCH;
                                    state_reg <= S_DONE;
                                end
                            end
                            default:              state_reg <= S_SCAN;
                        endcase
                    end
                end
                S_CAND:
                begin
                    k_reg <= '0;
                    if (i_reg == 4'd0)
                    begin
                        res_status_reg <= maat_pkg::ST_NO_FREE;
                        state_reg <= S_DONE;
                    end
                    else if (cand == 16'd0 || cand == cfg.default_address)
                    begin
                        i_reg <= i_reg - 4'd1;
                    end
                    else
                    begin
                        cand_reg <= cand;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (k_reg == count_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    k_reg <= k_reg + 1'b1;
                    state_reg <= S_SCAN;
                    case (cur_reg.kind)
                        maat_pkg::CMD_SET:
                        begin
                            if (id_hit)
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        maat_pkg::CMD_FIND_ID:
                        begin
                            if (id_hit)
                            begin
                                res_addr_reg <= e_addr;
                                state_reg <= S_DONE;
                            end
                        end
                        maat_pkg::CMD_FIND_ADDR:
                        begin
                            if (addr_hit)
                            begin
                                res_id_reg <= e_id;
                                state_reg <= S_DONE;
                            end
                        end
                        maat_pkg::CMD_ALLOC:
                        begin
                            if (held)
                            begin
                                i_reg <= i_reg - 4'd1;
                                state_reg <= S_CAND;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_FINISH:
                begin
                    state_reg <= S_DONE;
                    case (cur_reg.kind)
                        maat_pkg::CMD_SET:
                        begin
                            if (full)
                            begin
                                res_status_reg <= maat_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        maat_pkg::CMD_FIND_ID,
                        maat_pkg::CMD_FIND_ADDR:
                        begin
                            res_status_reg <= maat_pkg::ST_NOT_FOUND;
                        end
                        maat_pkg::CMD_ALLOC:
                        begin
                            pend_addr_reg <= cand_reg;
                            pend_id_reg <= cur_reg.id;
                            res_addr_reg <= cand_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg <= res_status_reg;
                        address_out_reg <= res_addr_reg;
                        node_id_out_reg <= res_id_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/mesh_address_allocation_table.sv]
// A command answered without a table walk goes straight to the result; lookups,
//   set and release walk the stored entries in order.
// Allocate walks the table once per candidate.
// One command is carried out at a time by the table walker;
//   a two-deep command queue accepts further transfers meanwhile.
// Reset empties the table (entry count zero), clears the pending pair and
//   returns the registers to their defaults.
`default_nettype none

module mesh_address_allocation_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  operation,
    input  wire logic [7:0]  node_id,
    input  wire logic [15:0] address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [15:0]      address_out,
    output logic [7:0]       node_id_out
);

    maat_pkg::cfg_t       cfg_reg;
    logic                 q_valid;
    maat_pkg::cmd_t       q_data;
    logic                 q_pop;
    maat_pkg::back_stat_t stat;

    assign pready = 1'b1;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.default_address <= 16'd2340;
            cfg_reg.max_children <= 3'd4;
            cfg_reg.own_node_id <= 8'd0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                maat_pkg::REG_DEFAULT_ADDRESS: cfg_reg.default_address <= pwdata[15:0];
                maat_pkg::REG_MAX_CHILDREN:    cfg_reg.max_children <= pwdata[2:0];
                maat_pkg::REG_OWN_NODE_ID:     cfg_reg.own_node_id <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // read back configuration registers
    always_comb
    begin
        case (paddr[3:2])
            maat_pkg::REG_DEFAULT_ADDRESS: prdata = {16'd0, cfg_reg.default_address};
            maat_pkg::REG_MAX_CHILDREN:    prdata = {29'd0, cfg_reg.max_children};
            maat_pkg::REG_OWN_NODE_ID:     prdata = {24'd0, cfg_reg.own_node_id};
            default:                       prdata = 32'd0;
        endcase
    end

    maat_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .operation(operation),
        .node_id  (node_id),
        .address  (address),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    maat_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .address_out(address_out),
        .node_id_out(node_id_out),
        .stat       (stat)
    );

    // table never holds more entries than it has rows
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= maat_pkg::CntW'(maat_pkg::TableEntries))
        else $error("entry count beyond table size");

    // entry count grows by at most one per cycle and never shrinks
    assert property (@(posedge clk) disable iff (!rst_n)
        (stat.count == $past(stat.count)) || (stat.count == $past(stat.count) + 1'b1))
        else $error("entry count jumped");

    // a delivered status is a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= maat_pkg::ST_MISMATCH))
        else $error("undefined status code");

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");

endmodule

`default_nettype wire
